FILE: rtl/texture_unswizzle_address_defines.svh
// Assertion macros for the texture unswizzle address block.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef TEXTURE_UNSWIZZLE_ADDRESS_DEFINES_SVH
`define TEXTURE_UNSWIZZLE_ADDRESS_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TXU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("txunswz assertion failed");

// Next-cycle implication, disabled during reset.
`define TXU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("txunswz assertion failed");

`endif

FILE: rtl/txunswz_pkg.sv
// Shared types and constants for the texture unswizzle address block.
// No dependencies.
`default_nettype none

package txunswz_pkg;

	localparam int MAX_SIDE_LOG2_DEF = 11;
	localparam int ADDR_W            = 24;
	localparam int TEXEL_W           = 32;
	localparam int SIDE_W            = 4;
	localparam int BPT_W             = 3;
	localparam int CFG_IDX_W         = 2;
	localparam int CFG_DATA_W        = 4;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES       = 2'd2;

	localparam logic [BPT_W-1:0] BYTES_RESET = 3'd4;

	// Effective configuration, sides already saturated.
	typedef struct packed {
		logic [SIDE_W-1:0] wl;
		logic [SIDE_W-1:0] hl;
		logic [BPT_W-1:0]  bpt;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/texture_unswizzle_address.sv
// Texture unswizzle address generator, top level.
// Uses txunswz_pkg, txunswz_cfg, txunswz_index and txunswz_addr.
//
// Usage:
//  - Texels enter in Morton order on texel_data with in_valid/in_ready; each
//    accepted word gets the next texel index (0 after reset).
//  - Each result word on out_valid/out_ready carries texel_out (the texel as
//    given), dest_byte_address = bytes_per_texel * (x + y*width), truncated
//    to 24 bits, and image_done on the last texel of the image.
//  - cfg_write/cfg_index/cfg_data load width_log2 (0), height_log2 (1) and
//    bytes_per_texel (2); write only while the pipe is empty. Sides above
//    MAX_SIDE_LOG2 saturate. The index is not cleared by a write.
//  - Path: an accepted word enters the input register, then the
//    deinterleave/multiply result is taken into the result register,
//    which drives out_valid.
//  - Throughput: one word per cycle with out_ready high; the single index
//    counter steps per accept; address logic is one short combinational pass.
//  - Stall: with out_ready low the result register holds; one more word sits
//    in the input register, after which in_ready drops. in_ready follows
//    out_ready combinationally when both stages are full.
//  - Reset (arst_n low): both stages empty, index 0, width/height 1 texel,
//    4 bytes per texel.
`default_nettype none

module texture_unswizzle_address #(
	parameter int MAX_SIDE_LOG2 = txunswz_pkg::MAX_SIDE_LOG2_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [txunswz_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [txunswz_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [txunswz_pkg::TEXEL_W-1:0]      texel_data,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [txunswz_pkg::ADDR_W-1:0]            dest_byte_address,
	output logic [txunswz_pkg::TEXEL_W-1:0]           texel_out,
	output logic                                      image_done
);

	localparam int IDX_W = 2 * MAX_SIDE_LOG2;

	txunswz_pkg::cfg_t cfg;

	logic             accept;
	logic             load_s2;
	logic [IDX_W-1:0] index;
	logic [IDX_W-1:0] last;

	// stage 1: input register
	logic                              valid_s1;
	logic [txunswz_pkg::TEXEL_W-1:0]   texel_s1;
	logic [IDX_W-1:0]                  index_s1;

	// stage 2: result register
	logic                              valid_s2;
	logic [txunswz_pkg::TEXEL_W-1:0]   texel_s2;
	logic [txunswz_pkg::ADDR_W-1:0]    addr_s2;
	logic                              done_s2;

	logic [txunswz_pkg::ADDR_W-1:0]    addr_d;
	logic                              done_d;

	txunswz_cfg #(
		.MAX_SIDE_LOG2(MAX_SIDE_LOG2)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	txunswz_index #(
		.MAX_SIDE_LOG2(MAX_SIDE_LOG2),
		.IDX_W        (IDX_W)
	) u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.cfg    (cfg),
		.index  (index),
		.last   (last)
	);

	txunswz_addr #(
		.MAX_SIDE_LOG2(MAX_SIDE_LOG2),
		.IDX_W        (IDX_W)
	) u_addr (
		.index (index_s1),
		.last  (last),
		.cfg   (cfg),
		.addr  (addr_d),
		.done  (done_d)
	);

	// result register takes a word when empty or draining
	assign load_s2  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || load_s2;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			texel_s1 <= texel_data;
			index_s1 <= index;
		end
		if (load_s2 && valid_s1) begin
			texel_s2 <= texel_s1;
			addr_s2  <= addr_d;
			done_s2  <= done_d;
		end
	end

	assign out_valid         = valid_s2;
	assign texel_out         = texel_s2;
	assign dest_byte_address = addr_s2;
	assign image_done        = done_s2;

endmodule

`default_nettype wire

FILE: rtl/txunswz_cfg.sv
// Configuration registers with side saturation.
// Depends on txunswz_pkg.
`default_nettype none

module txunswz_cfg #(
	parameter int MAX_SIDE_LOG2 = txunswz_pkg::MAX_SIDE_LOG2_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_write,
	input  wire logic [txunswz_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [txunswz_pkg::CFG_DATA_W-1:0]   cfg_data,
	output txunswz_pkg::cfg_t                         cfg
);

	localparam logic [txunswz_pkg::SIDE_W-1:0] SIDE_MAX = txunswz_pkg::SIDE_W'(MAX_SIDE_LOG2);

	logic [txunswz_pkg::SIDE_W-1:0] width_q;
	logic [txunswz_pkg::SIDE_W-1:0] height_q;
	logic [txunswz_pkg::BPT_W-1:0]  bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			bytes_q  <= txunswz_pkg::BYTES_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				txunswz_pkg::REG_WIDTH_LOG2:  width_q  <= cfg_data;
				txunswz_pkg::REG_HEIGHT_LOG2: height_q <= cfg_data;
				txunswz_pkg::REG_BYTES:       bytes_q  <= cfg_data[txunswz_pkg::BPT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.wl  = (width_q > SIDE_MAX) ? SIDE_MAX : width_q;
		cfg.hl  = (height_q > SIDE_MAX) ? SIDE_MAX : height_q;
		cfg.bpt = bytes_q;
	end

endmodule

`default_nettype wire

FILE: rtl/txunswz_index.sv
// Running texel index with wrap at the last texel of the image.
// Depends on txunswz_pkg.
`default_nettype none

module txunswz_index #(
	parameter int MAX_SIDE_LOG2 = txunswz_pkg::MAX_SIDE_LOG2_DEF,
	parameter int IDX_W         = 2 * MAX_SIDE_LOG2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  txunswz_pkg::cfg_t      cfg,
	output logic [IDX_W-1:0]       index,
	output logic [IDX_W-1:0]       last
);

	localparam int TOT_W = $clog2(IDX_W + 1);

	logic [TOT_W-1:0] total_bits;
	logic [IDX_W-1:0] index_q;

	assign total_bits = TOT_W'(cfg.wl) + TOT_W'(cfg.hl);
	// all ones below total_bits
	assign last  = ~({IDX_W{1'b1}} << total_bits);
	assign index = index_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q <= '0;
		end else if (step) begin
			// any index at or past the last texel wraps
			if (index_q >= last) begin
				index_q <= '0;
			end else begin
				index_q <= index_q + IDX_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/txunswz_addr.sv
// Morton deinterleave, linear address and last-texel flag (combinational).
// Depends on txunswz_pkg.
`default_nettype none

module txunswz_addr #(
	parameter int MAX_SIDE_LOG2 = txunswz_pkg::MAX_SIDE_LOG2_DEF,
	parameter int IDX_W         = 2 * MAX_SIDE_LOG2
) (
	input  wire logic [IDX_W-1:0]                   index,
	input  wire logic [IDX_W-1:0]                   last,
	input  txunswz_pkg::cfg_t                       cfg,
	output logic [txunswz_pkg::ADDR_W-1:0]          addr,
	output logic                                    done
);

	localparam int POS_W = (IDX_W > 1) ? $clog2(IDX_W) : 1;
	localparam int MUL_W = (IDX_W + txunswz_pkg::BPT_W > txunswz_pkg::ADDR_W) ?
		IDX_W + txunswz_pkg::BPT_W : txunswz_pkg::ADDR_W;

	logic [IDX_W-1:0]         idx_m;
	logic [MAX_SIDE_LOG2-1:0] x;
	logic [MAX_SIDE_LOG2-1:0] y;
	logic [POS_W-1:0]         xpos [MAX_SIDE_LOG2];
	logic [POS_W-1:0]         ypos [MAX_SIDE_LOG2];
	logic [IDX_W-1:0]         linear;
	logic [MUL_W-1:0]         prod;

	assign idx_m = index & last;
	assign done  = (idx_m == last);

	// Bit i of x sits at 2i while y still has bits, else at hl+i; y mirrors it.
	always_comb begin
		for (int i = 0; i < MAX_SIDE_LOG2; i++) begin
			xpos[i] = (txunswz_pkg::SIDE_W'(i) < cfg.hl) ? POS_W'(2 * i)
				: POS_W'(i) + POS_W'(cfg.hl);
			ypos[i] = (txunswz_pkg::SIDE_W'(i) < cfg.wl) ? POS_W'(2 * i + 1)
				: POS_W'(i) + POS_W'(cfg.wl);
			x[i] = (txunswz_pkg::SIDE_W'(i) < cfg.wl) ? idx_m[xpos[i]] : 1'b0;
			y[i] = (txunswz_pkg::SIDE_W'(i) < cfg.hl) ? idx_m[ypos[i]] : 1'b0;
		end
	end

	// x stays below 2^wl, so the add is an OR
	assign linear = IDX_W'(x) | (IDX_W'(y) << cfg.wl);
	assign prod   = MUL_W'(linear) * MUL_W'(cfg.bpt);
	assign addr   = prod[txunswz_pkg::ADDR_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/txunswz_chk.sv
// Port-level checker for texture_unswizzle_address, bound to the top level.
// Depends on txunswz_pkg and texture_unswizzle_address_defines.svh.
`default_nettype none
`include "texture_unswizzle_address_defines.svh"

module txunswz_chk (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_ready,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic [txunswz_pkg::ADDR_W-1:0]       dest_byte_address,
	input wire logic [txunswz_pkg::TEXEL_W-1:0]      texel_out,
	input wire logic                                 image_done
);

	logic [txunswz_pkg::ADDR_W+txunswz_pkg::TEXEL_W:0] out_word;

	assign out_word = {dest_byte_address, texel_out, image_done};

	// a stalled result word holds
	`TXU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

	// empty result register never backs up the input
	`TXU_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

	// an accepted word reaches the result register when the receiver keeps up
	`TXU_ASSERT_NEXT(a_latency, (in_valid && in_ready) ##1 out_ready, out_valid)

endmodule

bind texture_unswizzle_address txunswz_chk u_chk (.*);

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for texture_unswizzle_address: Morton index to linear byte address.
// Depends on txunswz_pkg and the RTL top; self-checking, no external files.

// One result word as the block should present it.
typedef struct packed {
	logic [txunswz_pkg::ADDR_W-1:0]  address;
	logic [txunswz_pkg::TEXEL_W-1:0] texel;
	logic                            last;
} texel_word_t;

// Tracks the register file and texel counter, and holds the words still owed.
class unswizzle_board;
	localparam int SIDE_MAX = txunswz_pkg::MAX_SIDE_LOG2_DEF;
	localparam int IDX_W    = 2 * SIDE_MAX;

	logic [txunswz_pkg::SIDE_W-1:0] width_log2;
	logic [txunswz_pkg::SIDE_W-1:0] height_log2;
	logic [txunswz_pkg::BPT_W-1:0]  bytes;
	logic [IDX_W-1:0]               texel_index;
	texel_word_t                    pending_words[$];
	int                             failures;

	function new();
		width_log2  = '0;
		height_log2 = '0;
		bytes       = txunswz_pkg::BYTES_RESET;
		texel_index = '0;
		failures    = 0;
	endfunction

	function void set_reg(logic [txunswz_pkg::CFG_IDX_W-1:0] idx,
			logic [txunswz_pkg::CFG_DATA_W-1:0] value);
		case (idx)
			txunswz_pkg::REG_WIDTH_LOG2: begin
				width_log2 = value;
			end
			txunswz_pkg::REG_HEIGHT_LOG2: begin
				height_log2 = value;
			end
			txunswz_pkg::REG_BYTES: begin
				bytes = value[txunswz_pkg::BPT_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Works out where this texel lands, then advances the counter.
	function void note_texel(logic [txunswz_pkg::TEXEL_W-1:0] texel);
		int unsigned     wl, hl, xi, yi, pos;
		logic [IDX_W:0]  span;
		logic [IDX_W-1:0] last_idx, idx, linear;
		logic [SIDE_MAX-1:0] x, y;
		logic [IDX_W+2:0] product;
		texel_word_t     word;

		wl = (width_log2 > SIDE_MAX) ? SIDE_MAX : width_log2;
		hl = (height_log2 > SIDE_MAX) ? SIDE_MAX : height_log2;
		span = ({{IDX_W{1'b0}}, 1'b1} << (wl + hl)) - 1'b1;
		last_idx = span[IDX_W-1:0];
		idx = texel_index & last_idx;

		// bit 0 upward: x then y while both have bits, then the leftover side
		x = '0;
		y = '0;
		xi = 0;
		yi = 0;
		pos = 0;
		while (xi < wl || yi < hl) begin
			if (xi < wl) begin
				x[xi] = idx[pos];
				xi++;
				pos++;
			end
			if (yi < hl) begin
				y[yi] = idx[pos];
				yi++;
				pos++;
			end
		end

		linear = IDX_W'(x) + (IDX_W'(y) << wl);
		product = (IDX_W+3)'(bytes) * (IDX_W+3)'(linear);
		word.address = product[txunswz_pkg::ADDR_W-1:0];
		word.texel = texel;
		word.last = (idx == last_idx);
		pending_words.push_back(word);

		// index survives reconfiguration, so it may sit past the last texel
		if (texel_index >= last_idx)
			texel_index = '0;
		else
			texel_index = texel_index + 1'b1;
	endfunction

	function void check_word(logic [txunswz_pkg::ADDR_W-1:0] address,
			logic [txunswz_pkg::TEXEL_W-1:0] texel, logic last);
		texel_word_t want;

		if (pending_words.size() == 0) begin
			$error("result word with none outstanding: address %h texel %h", address, texel);
			failures++;
			return;
		end
		want = pending_words.pop_front();
		if (address !== want.address) begin
			$error("dest_byte_address: expected %h, got %h", want.address, address);
			failures++;
		end
		if (texel !== want.texel) begin
			$error("texel_out: expected %h, got %h", want.texel, texel);
			failures++;
		end
		if (last !== want.last) begin
			$error("image_done: expected %b, got %b", want.last, last);
			failures++;
		end
	endfunction
endclass

module tb;
	localparam int PERIOD        = 12;
	localparam int RESET_CYCLES  = 6;
	localparam int RANDOM_TEXELS = 1400;
	localparam int IDLE_LIMIT    = 2000;
	localparam int FLUSH_CYCLES  = 10;
	// index 3 has no register behind it; writes there must be ignored
	localparam logic [txunswz_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [txunswz_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [txunswz_pkg::CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [txunswz_pkg::TEXEL_W-1:0] texel_data;
	logic out_valid;
	logic out_ready;
	logic [txunswz_pkg::ADDR_W-1:0] dest_byte_address;
	logic [txunswz_pkg::TEXEL_W-1:0] texel_out;
	logic image_done;

	unswizzle_board board;
	bit source_gappy;   // sender inserts random gaps between words
	bit sink_gappy;     // receiver stalls at random before each word
	int idle_cycles;

	always #(PERIOD / 2) clk = ~clk;

	texture_unswizzle_address dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.texel_data        (texel_data),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.dest_byte_address (dest_byte_address),
		.texel_out         (texel_out),
		.image_done        (image_done)
	);

	// Mostly random texels, with the all-zero and all-one patterns mixed in.
	function automatic logic [txunswz_pkg::TEXEL_W-1:0] random_texel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Sides lean small so images complete and wrap often.
	function automatic logic [txunswz_pkg::SIDE_W-1:0] random_side();
		if ($urandom_range(0, 9) < 7)
			return txunswz_pkg::SIDE_W'($urandom_range(0, 3));
		return txunswz_pkg::SIDE_W'($urandom_range(0, 15));
	endfunction

	// Entered and left at a falling edge; valid stays high on return so a
	// back-to-back word does not drop it.
	task automatic push_texel(input logic [txunswz_pkg::TEXEL_W-1:0] word);
		int unsigned gap;
		gap = source_gappy ? $urandom_range(0, 10) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		texel_data <= word;
		do @(posedge clk); while (!in_ready);
		board.note_texel(word);
		@(negedge clk);
	endtask

	// Lower valid, then wait for every owed word; returns at a falling edge.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (board.pending_words.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	// Only called with the pipe empty.
	task automatic write_reg(input logic [txunswz_pkg::CFG_IDX_W-1:0] idx,
			input logic [txunswz_pkg::CFG_DATA_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		board.set_reg(idx, value);
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_shape(input logic [txunswz_pkg::SIDE_W-1:0] w,
			input logic [txunswz_pkg::SIDE_W-1:0] h,
			input logic [txunswz_pkg::CFG_DATA_W-1:0] b);
		write_reg(txunswz_pkg::REG_WIDTH_LOG2, w);
		write_reg(txunswz_pkg::REG_HEIGHT_LOG2, h);
		write_reg(txunswz_pkg::REG_BYTES, b);
	endtask

	// Receiver: random stall per word, samples at the rising edge.
	initial begin
		int unsigned gap;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			gap = sink_gappy ? $urandom_range(0, 10) : 0;
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			board.check_word(dest_byte_address, texel_out, image_done);
		end
	end

	// Watchdog: trips on a long stretch with no handshake on either side.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int count;

		board        = new();
		arst_n       = 1'b0;
		cfg_write    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		texel_data   = '0;
		source_gappy = 1'b1;
		sink_gappy   = 1'b1;
		sent         = 0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset shape is 1x1: every word at address 0 and flagged last
		push_texel('0);
		push_texel('1);
		push_texel(32'h5A5A_A5A5);
		drain_results();

		// stray index ignored; bytes bit 3 dropped (odd count 7); 4x2 image
		// run past its end to see the wrap
		write_reg(REG_UNUSED, 4'hF);
		write_reg(txunswz_pkg::REG_BYTES, 4'hF);
		write_reg(txunswz_pkg::REG_WIDTH_LOG2, 4'd2);
		write_reg(txunswz_pkg::REG_HEIGHT_LOG2, 4'd1);
		repeat (9) push_texel(random_texel());
		drain_results();

		// oversized sides saturate; zero bytes gives address 0 throughout
		set_shape(4'd15, 4'd15, 4'd0);
		repeat (2) push_texel(random_texel());
		drain_results();

		// shrink mid-image: the kept index is reduced to the new size
		set_shape(4'd0, 4'd3, 4'd1);
		repeat (6) push_texel(random_texel());
		drain_results();

		// largest legal image, widest bytes
		set_shape(4'd11, 4'd11, 4'd7);
		repeat (3) push_texel(random_texel());
		drain_results();

		// index now past a 2x1 image, so the first word wraps
		set_shape(4'd1, 4'd0, 4'd2);
		repeat (2) push_texel(random_texel());

		// random phases: new settings between phases, counter carried over
		while (sent < RANDOM_TEXELS) begin
			drain_results();
			if ($urandom_range(0, 3) != 0)
				write_reg(txunswz_pkg::REG_WIDTH_LOG2, random_side());
			if ($urandom_range(0, 3) != 0)
				write_reg(txunswz_pkg::REG_HEIGHT_LOG2, random_side());
			if ($urandom_range(0, 2) != 0)
				write_reg(txunswz_pkg::REG_BYTES,
					txunswz_pkg::CFG_DATA_W'($urandom_range(0, 15)));
			source_gappy = ($urandom_range(0, 3) != 0);
			sink_gappy   = ($urandom_range(0, 3) != 0);
			count = $urandom_range(1, 60);
			repeat (count) push_texel(random_texel());
			sent += count;
		end

		drain_results();
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (board.failures == 0 && board.pending_words.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
